FILE: rtl/tiny_language_lexer_core_assert.svh
// Assertion macros shared by the checker of the TINY lexer core.
// Needs no package; the including file supplies clock and reset names.
`ifndef TINY_LANGUAGE_LEXER_CORE_ASSERT_SVH
`define TINY_LANGUAGE_LEXER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define TLL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication, masked during reset.
`define TLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

FILE: rtl/tll_pkg.sv
// Shared types, constants and character helpers of the TINY lexer core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tll_pkg;

    localparam int unsigned MAX_TOKEN_LEN_DEF = 32;
    // Length fields carried between modules; wide enough for the largest buffer (48).
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned TAG_W  = 4;
    localparam int unsigned OUT_W  = 16;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_ASSIGN = 3'd2,
        KIND_SYMBOL = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam int unsigned WORD_CNT = 8;
    localparam int unsigned WORD_MAX = 6;

    localparam logic [7:0] WORD_TEXT [WORD_CNT][WORD_MAX] = '{
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},   // if
        '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00},   // then
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},   // else
        '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00},   // end
        '{8'h72, 8'h65, 8'h70, 8'h65, 8'h61, 8'h74},   // repeat
        '{8'h75, 8'h6E, 8'h74, 8'h69, 8'h6C, 8'h00},   // until
        '{8'h72, 8'h65, 8'h61, 8'h64, 8'h00, 8'h00},   // read
        '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00}    // write
    };

    localparam logic [LEN_W-1:0] WORD_LEN [WORD_CNT] = '{
        6'd2, 6'd4, 6'd4, 6'd3, 6'd6, 6'd5, 6'd4, 6'd5
    };

    // One queued token: either buffered in a bank, or a lone character carried inline.
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] length;
        kind_t            kind;
        logic [TAG_W-1:0] tag;
        logic             trunc;
        logic             is_inline;
        logic [7:0]       ch;
    } job_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } buf_wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } buf_rel_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_EQUAL || c == CH_STAR ||
               c == CH_SLASH || c == CH_SEMI || c == CH_LT || c == CH_GT ||
               c == CH_LPAREN || c == CH_RPAREN;
    endfunction

    // Narrows the candidate set of reserved words by the character at pos.
    function automatic logic [WORD_CNT-1:0] match_step(input logic [WORD_CNT-1:0] m,
                                                       input logic [LEN_W-1:0]    pos,
                                                       input logic [7:0]          c);
        logic [WORD_CNT-1:0] r;
        for (int w = 0; w < WORD_CNT; w++) begin
            r[w] = (pos < LEN_W'(WORD_MAX)) ? (m[w] && WORD_TEXT[w][pos[2:0]] == c) : 1'b0;
        end
        return r;
    endfunction

    function automatic logic [TAG_W-1:0] reserved_tag(input logic [WORD_CNT-1:0] m,
                                                     input logic [LEN_W-1:0]    len);
        logic [TAG_W-1:0] t;
        t = '0;
        for (int w = WORD_CNT - 1; w >= 0; w--) begin
            if (m[w] && WORD_LEN[w] == len)
                t = TAG_W'(w + 1);
        end
        return t;
    endfunction

endpackage

FILE: rtl/tll_queue.sv
// Two-entry job queue between the scanner front end and the emitter.
// Depends on tll_pkg for the job type.
`timescale 1ns / 1ps

module tll_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tll_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output tll_pkg::job_t dout,
    output logic          empty
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    tll_pkg::job_t   ent_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign dout    = ent_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= din;
    end

endmodule

FILE: rtl/tll_front.sv
// Scanner front end: takes characters, runs the TINY scan modes, fills token banks
// and queues finished tokens. Depends on tll_pkg.
`timescale 1ns / 1ps

module tll_front
#(
    parameter int unsigned MAX_TOKEN_LEN = tll_pkg::MAX_TOKEN_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_char,
    input  logic              in_eoi,
    input  logic              q_full,
    output logic              push,
    output tll_pkg::job_t     push_job,
    output tll_pkg::buf_wr_t  buf_wr,
    input  tll_pkg::buf_rel_t buf_rel
);

    localparam int unsigned LW  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int unsigned JLW = tll_pkg::LEN_W;
    localparam int unsigned WC  = tll_pkg::WORD_CNT;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_SCAN  = 3'b010,
        PH_FLUSH = 3'b100
    } phase_t;

    typedef enum logic [4:0] {
        MODE_INITIAL = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_LETTER  = 5'b00100,
        MODE_DIGIT   = 5'b01000,
        MODE_ASSIGN  = 5'b10000
    } mode_t;

    phase_t          phase_reg, phase_next;
    mode_t           mode_reg, mode_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            ovf_reg, ovf_next;
    tll_pkg::kind_t  kind_reg, kind_next;
    logic [WC-1:0]   match_reg, match_next;
    logic            bank_reg, bank_next;
    logic [1:0]      busy_reg, busy_next;
    logic [7:0]      char_reg, char_next;
    logic            eoi_reg, eoi_next;

    logic            consume, append, flush_req, assign_eq;

    assign in_ready = (phase_reg == PH_IDLE);

    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        kind_next  = kind_reg;
        match_next = match_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        char_next  = char_reg;
        eoi_next   = eoi_reg;
        consume    = 1'b0;
        append     = 1'b0;
        flush_req  = 1'b0;
        assign_eq  = 1'b0;
        push       = 1'b0;
        push_job   = '0;
        buf_wr     = '0;
        buf_wr.bank = bank_reg;

        if (buf_rel.en)
            busy_next[buf_rel.bank] = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    char_next  = in_char;
                    eoi_next   = in_eoi;
                    phase_next = PH_SCAN;
                end
            end
            PH_SCAN:
            begin
                unique case (mode_reg)
                    MODE_COMMENT:
                    begin
                        consume = 1'b1;
                        if (char_reg == tll_pkg::CH_RBRACE)
                            mode_next = MODE_INITIAL;
                    end
                    MODE_LETTER:
                    begin
                        if (tll_pkg::is_letter(char_reg))
                        begin
                            append  = 1'b1;
                            consume = 1'b1;
                        end
                        else
                            flush_req = 1'b1;      // delimiter is rescanned once the token is queued
                    end
                    MODE_DIGIT:
                    begin
                        if (tll_pkg::is_digit(char_reg))
                        begin
                            append  = 1'b1;
                            consume = 1'b1;
                        end
                        else
                            flush_req = 1'b1;
                    end
                    MODE_ASSIGN:
                    begin
                        flush_req = 1'b1;
                        if (char_reg == tll_pkg::CH_EQUAL)
                        begin
                            // ':=' completes: write '=' and queue in one go
                            assign_eq     = 1'b1;
                            consume       = !q_full;
                            buf_wr.en     = !q_full;
                            buf_wr.addr   = JLW'(len_reg);
                            buf_wr.data   = char_reg;
                        end
                    end
                    MODE_INITIAL:
                    begin
                        priority if (char_reg == tll_pkg::CH_SPACE)
                            consume = 1'b1;
                        else if (char_reg == tll_pkg::CH_LBRACE)
                        begin
                            consume   = 1'b1;
                            mode_next = MODE_COMMENT;
                        end
                        else if (tll_pkg::is_digit(char_reg) || tll_pkg::is_letter(char_reg) ||
                                 char_reg == tll_pkg::CH_COLON)
                        begin
                            // a new token needs a bank the emitter has let go of
                            if (!busy_reg[bank_reg])
                            begin
                                consume     = 1'b1;
                                buf_wr.en   = 1'b1;
                                buf_wr.addr = '0;
                                buf_wr.data = char_reg;
                                len_next    = LW'(1);
                                ovf_next    = 1'b0;
                                match_next  = tll_pkg::match_step('1, '0, char_reg);
                                priority if (tll_pkg::is_digit(char_reg))
                                begin
                                    kind_next = tll_pkg::KIND_NUMBER;
                                    mode_next = MODE_DIGIT;
                                end
                                else if (tll_pkg::is_letter(char_reg))
                                begin
                                    kind_next = tll_pkg::KIND_IDENT;
                                    mode_next = MODE_LETTER;
                                end
                                else
                                begin
                                    kind_next = tll_pkg::KIND_ASSIGN;
                                    mode_next = MODE_ASSIGN;
                                end
                            end
                        end
                        else
                        begin
                            // symbols and stray bytes go out as one-character tokens
                            if (!q_full)
                            begin
                                consume            = 1'b1;
                                push               = 1'b1;
                                push_job.length    = JLW'(1);
                                push_job.kind      = tll_pkg::is_symbol(char_reg) ?
                                                     tll_pkg::KIND_SYMBOL :
                                                     tll_pkg::KIND_ERROR;
                                push_job.is_inline = 1'b1;
                                push_job.ch        = char_reg;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_INITIAL;
                    end
                endcase

                if (consume)
                    phase_next = eoi_reg ? PH_FLUSH : PH_IDLE;
            end
            PH_FLUSH:
            begin
                if (mode_reg == MODE_LETTER || mode_reg == MODE_DIGIT ||
                    mode_reg == MODE_ASSIGN)
                begin
                    flush_req = 1'b1;
                    if (!q_full)
                        phase_next = PH_IDLE;
                end
                else
                begin
                    mode_next  = MODE_INITIAL;       // open comment is dropped
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (append)
        begin
            if (len_reg < LW'(MAX_TOKEN_LEN))
            begin
                buf_wr.en   = 1'b1;
                buf_wr.addr = JLW'(len_reg);
                buf_wr.data = char_reg;
                len_next    = len_reg + LW'(1);
                match_next  = tll_pkg::match_step(match_reg, JLW'(len_reg), char_reg);
            end
            else
                ovf_next = 1'b1;
        end

        if (flush_req && !q_full)
        begin
            push               = 1'b1;
            push_job.bank      = bank_reg;
            push_job.length    = JLW'(len_reg) + (assign_eq ? JLW'(1) : JLW'(0));
            push_job.kind      = kind_reg;
            push_job.tag       = (kind_reg == tll_pkg::KIND_IDENT && !ovf_reg) ?
                                 tll_pkg::reserved_tag(match_reg, JLW'(len_reg)) : '0;
            push_job.trunc     = ovf_reg;
            push_job.is_inline = 1'b0;
            busy_next[bank_reg] = 1'b1;
            bank_next          = !bank_reg;
            mode_next          = MODE_INITIAL;
            len_next           = '0;
            ovf_next           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            mode_reg  <= MODE_INITIAL;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            kind_reg  <= tll_pkg::KIND_IDENT;
            match_reg <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            kind_reg  <= kind_next;
            match_reg <= match_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        eoi_reg  <= eoi_next;
    end

endmodule

FILE: rtl/tll_back.sv
// Emitter back end: holds the two token banks, replays queued tokens one character
// per word into a registered output stage. Depends on tll_pkg.
`timescale 1ns / 1ps

module tll_back
#(
    parameter int unsigned MAX_TOKEN_LEN = tll_pkg::MAX_TOKEN_LEN_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tll_pkg::buf_wr_t          buf_wr,
    output tll_pkg::buf_rel_t         buf_rel,
    input  logic                      q_empty,
    input  tll_pkg::job_t             q_job,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tll_pkg::OUT_W-1:0] out_data,
    output logic                      out_last
);

    localparam int unsigned AW  = $clog2(MAX_TOKEN_LEN);
    localparam int unsigned LW  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int unsigned JLW = tll_pkg::LEN_W;
    localparam int unsigned TW  = tll_pkg::TAG_W;

    logic [7:0]       mem [2][MAX_TOKEN_LEN];
    logic [7:0]       rd_data_reg;

    logic             job_vld_reg;
    tll_pkg::job_t    job_reg;
    logic [LW-1:0]    idx_reg;

    logic             pend_reg;
    logic             pend_last_reg;
    tll_pkg::kind_t   pend_kind_reg;
    logic [TW-1:0]    pend_tag_reg;
    logic             pend_trunc_reg;
    logic             pend_inline_reg;
    logic [7:0]       pend_ch_reg;

    logic                      out_valid_reg;
    logic [tll_pkg::OUT_W-1:0] out_data_reg;
    logic                      out_last_reg;

    logic             load, issue, last_idx, rd_en;
    logic [7:0]       pend_char;

    assign load      = pend_reg && (!out_valid_reg || out_ready);
    assign issue     = job_vld_reg && (!pend_reg || load);
    assign last_idx  = (JLW'(idx_reg) + JLW'(1)) == job_reg.length;
    assign pop       = !job_vld_reg && !q_empty;
    assign rd_en     = issue && !job_reg.is_inline;
    assign pend_char = pend_inline_reg ? pend_ch_reg : rd_data_reg;

    // bank goes back to the scanner once its last character has been read
    assign buf_rel.en   = rd_en && last_idx;
    assign buf_rel.bank = job_reg.bank;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
            mem[buf_wr.bank][buf_wr.addr[AW-1:0]] <= buf_wr.data;
        if (rd_en)
            rd_data_reg <= mem[job_reg.bank][idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_vld_reg   <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                job_vld_reg <= 1'b1;
                idx_reg     <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + LW'(1);
                if (last_idx)
                    job_vld_reg <= 1'b0;
            end

            if (issue)
                pend_reg <= 1'b1;
            else if (load)
                pend_reg <= 1'b0;

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        if (issue)
        begin
            pend_last_reg   <= last_idx;
            pend_kind_reg   <= job_reg.kind;
            pend_tag_reg    <= job_reg.tag;
            pend_trunc_reg  <= job_reg.trunc;
            pend_inline_reg <= job_reg.is_inline;
            pend_ch_reg     <= job_reg.ch;
        end
        if (load)
        begin
            out_data_reg <= {pend_trunc_reg, pend_tag_reg, pend_kind_reg, pend_char};
            out_last_reg <= pend_last_reg;
        end
    end

endmodule

FILE: rtl/tiny_language_lexer_core.sv
// Top level of the TINY language lexer: scanner front end, job queue, emitter.
// Depends on tll_pkg, tll_front, tll_queue and tll_back.
`timescale 1ns / 1ps

// Usage
//   Input stream: one source character per word on s_axis; tlast marks the last
//   character of the source, after which any pending token is flushed.
//   Output stream: one word per token character on m_axis, tlast on the final
//   character of each token. Spaces and {comments} produce nothing.
//   Scanning: the scanner takes a character and scans it before it takes the next;
//   a character that ends an identifier, number or lone ':' is scanned twice (the
//   token is queued, then the character is rescanned), and an end-of-source word
//   adds a flush step. The scanner stalls only when the two-deep token queue is
//   full or when both token banks are still being replayed.
//   Path: a token is queued by the scanner, taken from the queue as a job, staged
//   and registered onto m_axis. The emitter gives one character per cycle while
//   m_axis_tready is high, and takes the next job only after a token's last character.
//   Stall: when m_axis_tready is low the output word holds; the emitter and then
//   the queue fill, and finally s_axis_tready stays low.
//   Reset: rst_n (asynchronous, active low) empties the queue and output stage
//   and returns the scanner to its initial mode. Banks need no clearing pass.
module tiny_language_lexer_core
#(
    parameter int unsigned MAX_TOKEN_LEN = tll_pkg::MAX_TOKEN_LEN_DEF   // 6 to 48
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] char_code
    input  logic                      s_axis_tlast,   // end_of_input
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [tll_pkg::OUT_W-1:0] m_axis_tdata,   // [7:0] token_char, [10:8] token_kind,
                                                      // [14:11] reserved_word, [15] truncated
    output logic                      m_axis_tlast    // last_char
);

    tll_pkg::job_t     push_job, q_job;
    tll_pkg::buf_wr_t  buf_wr;
    tll_pkg::buf_rel_t buf_rel;
    logic              push, q_full, q_empty, pop;

    tll_front
    #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    )
    u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .in_eoi   (s_axis_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job),
        .buf_wr   (buf_wr),
        .buf_rel  (buf_rel)
    );

    // Decouples scanning from replay so either side can stall alone.
    tll_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_job),
        .full  (q_full),
        .pop   (pop),
        .dout  (q_job),
        .empty (q_empty)
    );

    tll_back
    #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .buf_wr    (buf_wr),
        .buf_rel   (buf_rel),
        .q_empty   (q_empty),
        .q_job     (q_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

FILE: rtl/tll_checker.sv
// Port-level checker for the TINY lexer core, attached by bind.
// Depends on tll_pkg and tiny_language_lexer_core_assert.svh.
`timescale 1ns / 1ps
`include "tiny_language_lexer_core_assert.svh"

module tll_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [tll_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);

    // The scanner works on one character at a time.
    `TLL_ASSERT_NEXT(a_one_char, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    `TLL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    `TLL_ASSERT_IMPLY(a_kind_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[10:8] <= tll_pkg::KIND_ERROR)

    // Reserved tags only on whole identifiers.
    `TLL_ASSERT_IMPLY(a_tag_ident, clk, rst_n, m_axis_tvalid && m_axis_tdata[14:11] != 4'd0, m_axis_tdata[10:8] == tll_pkg::KIND_IDENT && !m_axis_tdata[15] && m_axis_tdata[14:11] <= 4'd8)

endmodule

bind tiny_language_lexer_core tll_checker u_tll_checker (.*);

FILE: tb/tb_tiny_language_lexer_core.sv
// Self-checking testbench of the TINY lexer core: streams source characters in,
// predicts every token character and checks each output word in order.
// Depends on tll_pkg and tiny_language_lexer_core.
`timescale 1ns / 1ps

module tb_tiny_language_lexer_core;

    localparam int TOKEN_MAX = 32;

    // Scanner modes of the predictor
    typedef enum int {SC_START, SC_COMMENT, SC_WORD, SC_NUMBER, SC_COLON} scan_t;

    // One predicted output word
    typedef struct packed {
        logic [7:0]      ch;
        tll_pkg::kind_t  kind;
        logic [3:0]      tag;
        logic            cut;
        logic            last;
    } tok_char_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [tll_pkg::OUT_W-1:0] m_axis_tdata;
    logic                      m_axis_tlast;

    // Predictor state
    scan_t           lx_mode;
    logic [7:0]      lx_text [TOKEN_MAX];
    int              lx_len;
    tll_pkg::kind_t  lx_kind;
    logic            lx_cut;
    tok_char_t       token_chars_due [$];

    string rsv_words [8] = '{"if", "then", "else", "end", "repeat", "until", "read", "write"};
    string sym_chars = "+-=*/;<>()";

    int err_count;
    bit gaps_on;       // random idling on both sides
    int rx_hold_req;   // long receiver hold, picked up by the receiver process

    tiny_language_lexer_core #(
        .MAX_TOKEN_LEN (TOKEN_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic bit letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit symbol_ch(input logic [7:0] c);
        return c inside {tll_pkg::CH_PLUS, tll_pkg::CH_MINUS, tll_pkg::CH_EQUAL,
                         tll_pkg::CH_STAR, tll_pkg::CH_SLASH, tll_pkg::CH_SEMI,
                         tll_pkg::CH_LT, tll_pkg::CH_GT, tll_pkg::CH_LPAREN,
                         tll_pkg::CH_RPAREN};
    endfunction

    // Exact, case-sensitive match; cut identifiers never match
    function automatic logic [3:0] word_tag();
        bit hit;
        if (lx_kind != tll_pkg::KIND_IDENT || lx_cut)
            return 4'd0;
        for (int w = 0; w < 8; w++) begin
            if (rsv_words[w].len() == lx_len) begin
                hit = 1'b1;
                for (int k = 0; k < lx_len; k++)
                    if (rsv_words[w][k] != lx_text[k])
                        hit = 1'b0;
                if (hit)
                    return 4'(w + 1);
            end
        end
        return 4'd0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        if (lx_len < TOKEN_MAX) begin
            lx_text[lx_len] = c;
            lx_len++;
        end
        else begin
            lx_cut = 1'b1;
        end
    endfunction

    function automatic void open_token(input logic [7:0] c, input tll_pkg::kind_t kind);
        lx_len  = 0;
        lx_cut  = 1'b0;
        lx_kind = kind;
        take_char(c);
    endfunction

    // Queues the buffered token, one expected word per character
    function automatic void flush_token();
        logic [3:0] tag;
        tok_char_t  e;
        tag = word_tag();
        for (int k = 0; k < lx_len; k++) begin
            e.ch   = lx_text[k];
            e.kind = lx_kind;
            e.tag  = tag;
            e.cut  = lx_cut;
            e.last = (k == lx_len - 1);
            token_chars_due = {token_chars_due, e};
        end
        lx_len  = 0;
        lx_cut  = 1'b0;
        lx_mode = SC_START;
    endfunction

    function automatic void scan_fresh(input logic [7:0] c);
        if (c == tll_pkg::CH_SPACE) begin
            return;
        end
        else if (digit_ch(c)) begin
            open_token(c, tll_pkg::KIND_NUMBER);
            lx_mode = SC_NUMBER;
        end
        else if (c == tll_pkg::CH_COLON) begin
            open_token(c, tll_pkg::KIND_ASSIGN);
            lx_mode = SC_COLON;
        end
        else if (c == tll_pkg::CH_LBRACE) begin
            lx_mode = SC_COMMENT;
        end
        else if (letter_ch(c)) begin
            open_token(c, tll_pkg::KIND_IDENT);
            lx_mode = SC_WORD;
        end
        else if (symbol_ch(c)) begin
            open_token(c, tll_pkg::KIND_SYMBOL);
            flush_token();
        end
        else begin
            open_token(c, tll_pkg::KIND_ERROR);
            flush_token();
        end
    endfunction

    // One accepted source character; the delimiter of a token is rescanned
    function automatic void lex_char(input logic [7:0] c, input bit eoi);
        case (lx_mode)
            SC_COMMENT: begin
                if (c == tll_pkg::CH_RBRACE)
                    lx_mode = SC_START;
            end
            SC_WORD: begin
                if (letter_ch(c))
                    take_char(c);
                else begin
                    flush_token();
                    scan_fresh(c);
                end
            end
            SC_NUMBER: begin
                if (digit_ch(c))
                    take_char(c);
                else begin
                    flush_token();
                    scan_fresh(c);
                end
            end
            SC_COLON: begin
                if (c == tll_pkg::CH_EQUAL) begin
                    take_char(c);
                    flush_token();
                end
                else begin
                    flush_token();
                    scan_fresh(c);
                end
            end
            default: begin
                lx_mode = SC_START;
                scan_fresh(c);
            end
        endcase
        if (eoi) begin
            if (lx_mode inside {SC_WORD, SC_NUMBER, SC_COLON})
                flush_token();
            lx_mode = SC_START;
            lx_len  = 0;
            lx_cut  = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    always @(posedge clk) begin : out_check
        tok_char_t got;
        tok_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ch   = m_axis_tdata[7:0];
            got.kind = tll_pkg::kind_t'(m_axis_tdata[10:8]);
            got.tag  = m_axis_tdata[14:11];
            got.cut  = m_axis_tdata[15];
            got.last = m_axis_tlast;
            if (token_chars_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word char=%02h kind=%0d tag=%0d",
                                          got.ch, got.kind, got.tag));
            end
            else begin
                want = token_chars_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "char %02h/%02h kind %0d/%0d tag %0d/%0d cut %0b/%0b last %0b/%0b",
                        got.ch, want.ch, got.kind, want.kind, got.tag, want.tag,
                        got.cut, want.cut, got.last, want.last));
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial begin : rx_drive
        int stall_left;
        int calm_left;
        int hold_left;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        calm_left     = 0;
        hold_left     = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!gaps_on || calm_left > 0) begin
                if (calm_left > 0)
                    calm_left--;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        stall_left = $urandom_range(1, 7) - 1;
                        m_axis_tready <= 1'b0;
                    end
                    2: begin
                        calm_left = $urandom_range(10, 40);
                        m_axis_tready <= 1'b1;
                    end
                    default: m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // Offers one character and returns at the edge that takes it
    task automatic send_word(input logic [7:0] c, input bit eoi);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        do @(posedge clk); while (!s_axis_tready);
        lex_char(c, eoi);
    endtask

    // End flag goes on the last character only
    task automatic send_text(input string s, input bit eoi);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], eoi && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (token_chars_due.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    // Each token kind, delimiters, comments, stray brace, control and top bytes,
    // flush at the end flag, unterminated comment
    task automatic test_directed();
        send_text("if:=7", 1'b0);
        send_text(":x", 1'b0);
        send_text("{c}", 1'b0);
        send_text("}", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h09, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("+", 1'b0);
        send_text("ab", 1'b1);
        send_text("{z", 1'b1);
    endtask

    // Buffer boundary: exactly full, one over, and a long number flushed by the end flag
    task automatic test_long_tokens();
        string s;
        s = "";
        for (int i = 0; i < TOKEN_MAX; i++)
            s = $sformatf("%s%c", s, "a" + $urandom_range(0, 25));
        send_text({s, " "}, 1'b0);
        send_text({s, "Z "}, 1'b0);
        s = "";
        for (int i = 0; i < TOKEN_MAX + 2; i++)
            s = $sformatf("%s%c", s, "0" + $urandom_range(0, 9));
        send_text(s, 1'b1);
    endtask

    // Random TINY-like source: mostly well-formed tokens, some near misses and noise
    task automatic test_random_source(input int n_items);
        int    sent;
        int    len;
        string s;
        bit    eoi;
        sent = 0;
        while (sent < n_items) begin
            s   = "";
            eoi = ($urandom_range(0, 24) == 0);
            case ($urandom_range(0, 15))
                0, 1, 2: s = rsv_words[$urandom_range(0, 7)];
                3: begin
                    s = rsv_words[$urandom_range(0, 7)];
                    case ($urandom_range(0, 2))
                        0: s[0] = s[0] - 8'd32;
                        1: s = s.substr(0, s.len() - 2);
                        default: s = {s, "s"};
                    endcase
                end
                4, 5: begin
                    len = ($urandom_range(0, 31) == 0) ? $urandom_range(30, 36)
                                                        : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        s = $sformatf("%s%c", s, $urandom_range(0, 1) ?
                                      "a" + $urandom_range(0, 25) : "A" + $urandom_range(0, 25));
                end
                6, 7: begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        s = $sformatf("%s%c", s, "0" + $urandom_range(0, 9));
                end
                8: s = ":=";
                9: s = ":";
                10, 11: s = $sformatf("%c", sym_chars[$urandom_range(0, 9)]);
                12: begin
                    // comment body of arbitrary bytes, closing brace excluded
                    send_word(tll_pkg::CH_LBRACE, 1'b0);
                    len = $urandom_range(0, 5);
                    for (int i = 0; i < len; i++) begin
                        logic [7:0] b;
                        b = 8'($urandom_range(0, 255));
                        if (b == tll_pkg::CH_RBRACE)
                            b = tll_pkg::CH_LBRACE;
                        send_word(b, 1'b0);
                    end
                    s = "}";
                    sent += len + 1;
                end
                13: begin
                    send_word(8'($urandom_range(0, 255)), eoi);
                    sent++;
                end
                default: s = " ";
            endcase
            if (s.len() != 0) begin
                send_text(s, eoi);
                sent += s.len();
            end
            if ($urandom_range(0, 1) == 0) begin
                send_word(tll_pkg::CH_SPACE, 1'b0);
                sent++;
            end
        end
    endtask

    // Receiver holds off long while the sender keeps offering: queue fills, input stalls
    task automatic test_backpressure();
        rx_hold_req = 300;
        send_text("repeat x:=x+1; y := 42 until x>y ", 1'b0);
        send_text("write (x*3)/7-2 ", 1'b1);
    endtask

    // Sender pauses until every pending word is out, then carries on
    task automatic test_drain_pause();
        send_text("read q; ", 1'b0);
        wait_drained();
        send_text("if q<9 then end", 1'b1);
    endtask

    // ---------------------------------------------------------------- run

    initial begin : main_seq
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        gaps_on       = 1'b1;
        rx_hold_req   = 0;
        err_count     = 0;
        lx_mode       = SC_START;
        lx_len        = 0;
        lx_kind       = tll_pkg::KIND_IDENT;
        lx_cut        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_tokens();
        test_backpressure();
        test_random_source(110);
        test_drain_pause();
        gaps_on = 1'b0;
        test_random_source(50);
        send_word(tll_pkg::CH_SPACE, 1'b1);

        wait_drained();
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit: far beyond the slowest correct run
    initial begin : run_limit
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: tiny_language_lexer_core.f
+incdir+rtl
rtl/tll_pkg.sv
rtl/tll_queue.sv
rtl/tll_front.sv
rtl/tll_back.sv
rtl/tiny_language_lexer_core.sv
rtl/tll_checker.sv
tb/tb_tiny_language_lexer_core.sv
